[hw/rtl/chj_pkg.sv]
// shared constants, request codes, state type and port bundles for the
// chained hash join table; no dependencies
`default_nettype none

package chj_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 1024;
  localparam int HEAD_SLOTS  = 2048;

  // widths
  localparam int KEY_W  = 32;
  localparam int HASH_W = 32;
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int SLOT_W = $clog2(HEAD_SLOTS);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W  = KEY_W + IDX_W;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_PROBE  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_DONE
  } state_t;

  // head table port bundle
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [IDX_W-1:0]  wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } head_port_t;

  // entry store port bundle (key and link side by side)
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ent_port_t;

  // one result beat
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
    logic             full;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/chj_ram.sv]
// generic single-clock ram, one write and one read port, registered read
// no package dependencies
`default_nettype none

module chj_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/chj_ctrl.sv]
// sequencer for insert and probe: head clearing, head read, entry write,
// chain walk; depends on chj_pkg
`default_nettype none

module chj_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic                       req_type,
  input  wire logic signed [31:0]         key,
  input  wire logic [31:0]                hash,
  output      chj_pkg::head_port_t        head,
  input  wire logic [chj_pkg::IDX_W-1:0]  head_rdata,
  output      chj_pkg::ent_port_t         ent,
  input  wire logic [chj_pkg::ENT_W-1:0]  ent_rdata,
  output      logic                       res_valid,
  input  wire logic                       res_ready,
  output      chj_pkg::res_t              res
);

  import chj_pkg::*;

  state_t            state, state_next;
  logic [SLOT_W-1:0] clr_addr, clr_addr_next;
  logic              req_q, req_q_next;
  logic [KEY_W-1:0]  key_q, key_q_next;
  logic [SLOT_W-1:0] slot_q, slot_q_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic [CNT_W-1:0]  steps, steps_next;
  res_t              res_next;

  logic [KEY_W-1:0]  ent_key;
  logic [IDX_W-1:0]  ent_link;
  logic [CNT_W-1:0]  step_inc;

  assign ent_key  = ent_rdata[ENT_W-1:IDX_W];
  assign ent_link = ent_rdata[IDX_W-1:0];
  assign step_inc = steps + CNT_W'(1);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      count    <= CNT_W'(1);
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      count    <= count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_q  <= req_q_next;
    key_q  <= key_q_next;
    slot_q <= slot_q_next;
    cur    <= cur_next;
    steps  <= steps_next;
    res    <= res_next;
  end

  // next state and memory requests
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    req_q_next    = req_q;
    key_q_next    = key_q;
    slot_q_next   = slot_q;
    count_next    = count;
    cur_next      = cur;
    steps_next    = steps;
    res_next      = res;
    head          = '0;
    ent           = '0;
    in_ready      = 1'b0;
    res_valid     = 1'b0;

    case (state)
      // sweep every head slot to the null link
      ST_CLEAR: begin
        head.we       = 1'b1;
        head.waddr    = clr_addr;
        head.wdata    = '0;
        clr_addr_next = clr_addr + SLOT_W'(1);
        if (clr_addr == SLOT_W'(HEAD_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      // take a request and fetch its chain head
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_q_next  = req_type;
          key_q_next  = key;
          slot_q_next = hash[SLOT_W-1:0];
          head.re     = 1'b1;
          head.raddr  = hash[SLOT_W-1:0];
          state_next  = ST_HEAD;
        end
      end

      // head known: insert links in unless the table is full, probe starts its walk unless the chain is empty
      ST_HEAD: begin
        res_next = '0;
        if (req_q == REQ_INSERT) begin
          if (count >= CNT_W'(MAX_ENTRIES)) begin
            res_next.full = 1'b1;
          end else begin
            ent.we         = 1'b1;
            ent.waddr      = count[IDX_W-1:0];
            ent.wdata      = {key_q, head_rdata};
            head.we        = 1'b1;
            head.waddr     = slot_q;
            head.wdata     = count[IDX_W-1:0];
            res_next.index = count[IDX_W-1:0];
            count_next     = count + CNT_W'(1);
          end
          state_next = ST_DONE;
        end else if (head_rdata == '0) begin
          state_next = ST_DONE;
        end else begin
          ent.re     = 1'b1;
          ent.raddr  = head_rdata;
          cur_next   = head_rdata;
          steps_next = '0;
          state_next = ST_WALK;
        end
      end

      // compare one chain entry per cycle, follow its link on a miss
      ST_WALK: begin
        if (ent_key == key_q) begin
          res_next.found = 1'b1;
          res_next.index = cur;
          state_next     = ST_DONE;
        end else if (ent_link == '0 || step_inc >= CNT_W'(MAX_ENTRIES)) begin
          state_next = ST_DONE;
        end else begin
          ent.re     = 1'b1;
          ent.raddr  = ent_link;
          cur_next   = ent_link;
          steps_next = step_inc;
        end
      end

      // hand the result to the output register
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/chained_hash_join_table.sv]
// top level of the chained hash join table: head ram, entry ram, sequencer
// and output register; depends on chj_pkg, chj_ram, chj_ctrl
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid / in_ready  | req_type, key, hash
//   out     | output    | out_valid / out_ready| found, entry_index, table_full
//
// an insert reads its chain head, then writes the entry and new head; a probe
// reads its chain head, then compares chain entries one at a time over the
// single read port of the entry ram. after reset the head ram is swept to
// zero, one slot a cycle; in_ready stays low meanwhile. one item is in work
// at a time; the output register lets the next item be taken while a result
// waits, and a stalled output holds the finished item in the sequencer.
`default_nettype none

module chained_hash_join_table (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic                      req_type,
  input  wire logic signed [31:0]        key,
  input  wire logic [31:0]               hash,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic                      found,
  output      logic [9:0]                entry_index,
  output      logic                      table_full
);

  import chj_pkg::*;

  head_port_t       head;
  ent_port_t        ent;
  logic [IDX_W-1:0] head_rdata;
  logic [ENT_W-1:0] ent_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  // chain heads, one per slot
  chj_ram #(.DEPTH(HEAD_SLOTS), .WIDTH(IDX_W)) u_head_ram (
    .clk   (clk),
    .we    (head.we),
    .waddr (head.waddr),
    .wdata (head.wdata),
    .re    (head.re),
    .raddr (head.raddr),
    .rdata (head_rdata)
  );

  // keys and next links, one per entry
  chj_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(ENT_W)) u_ent_ram (
    .clk   (clk),
    .we    (ent.we),
    .waddr (ent.waddr),
    .wdata (ent.wdata),
    .re    (ent.re),
    .raddr (ent.raddr),
    .rdata (ent_rdata)
  );

  chj_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .key        (key),
    .hash       (hash),
    .head       (head),
    .head_rdata (head_rdata),
    .ent        (ent),
    .ent_rdata  (ent_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      found       <= res.found;
      entry_index <= res.index;
      table_full  <= res.full;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/chj_checker.sv]
// port-level checks for chained_hash_join_table, bound to the top level
// no package dependencies
`default_nettype none

module chj_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        found,
  input wire logic [9:0]  entry_index,
  input wire logic        table_full
);

  // one item in work: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a result is never both a hit and a refusal
  a_found_full_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && table_full))
    else $error("found and table_full both set");

  // a refused insert reports the null entry
  a_full_null: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (entry_index == 10'd0))
    else $error("refused insert with nonzero entry");

  // a hit never names the reserved entry
  a_hit_nonnull: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (entry_index != 10'd0))
    else $error("probe hit on the null entry");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(entry_index)))
    else $error("output beat changed while stalled");

endmodule

bind chained_hash_join_table chj_props u_chj_props (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .found       (found),
  .entry_index (entry_index),
  .table_full  (table_full)
);

`default_nettype wire
